// ===== design/fvad_pkg.sv =====
`timescale 1ns / 1ps
package fvad_pkg;

	localparam int XY_W    = 12;
	localparam int MAG_W   = 12;
	localparam int NUM_W   = 17;
	localparam int QUOT_W  = 6;
	localparam int ANGLE_W = 9;

	// request fields, one vector
	typedef struct packed {
		logic signed [XY_W-1:0] x_component;
		logic signed [XY_W-1:0] y_component;
	} fvad_in_t;

	// result fields
	typedef struct packed {
		logic [ANGLE_W-1:0] angle_degrees;
		logic               zero_vector;
	} fvad_out_t;

	// flags that ride along with the division
	typedef struct packed {
		logic xneg;
		logic yneg;
		logic mirror;
		logic zero;
	} fvad_side_t;

	// divider pipeline word
	typedef struct packed {
		logic [NUM_W-1:0]  rem;
		logic [NUM_W-1:0]  dsh;
		logic [QUOT_W-1:0] quot;
		fvad_side_t        side;
	} fvad_div_t;

endpackage

// ===== design/fvad_front.sv =====
`timescale 1ns / 1ps
module fvad_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic                in_valid,
	input  fvad_pkg::fvad_in_t  in_data,
	output logic                out_valid,
	output fvad_pkg::fvad_div_t out_data
);
	import fvad_pkg::*;

	logic [MAG_W-1:0] xr, yr, ax, ay;
	logic [MAG_W-1:0] ax_s1, ay_s1;
	logic             xneg_s1, yneg_s1, v_s1;
	logic [MAG_W-1:0] mag_lo, mag_hi;
	logic [NUM_W-1:0] num;
	logic             mirror;
	fvad_div_t        div_s2;
	logic             v_s2;

	// take magnitudes; the most negative code maps to its own magnitude
	always_comb begin
		xr = in_data.x_component;
		yr = in_data.y_component;
		ax = xr[MAG_W-1] ? (~xr + MAG_W'(1)) : xr;
		ay = yr[MAG_W-1] ? (~yr + MAG_W'(1)) : yr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ax_s1   <= ax;
			ay_s1   <= ay;
			xneg_s1 <= xr[MAG_W-1];
			yneg_s1 <= yr[MAG_W-1];
		end
	end

	// pick smaller over larger, scale the smaller by 45
	always_comb begin
		mirror = ax_s1 > ay_s1;
		mag_lo = mirror ? ay_s1 : ax_s1;
		mag_hi = mirror ? ax_s1 : ay_s1;
		num    = {mag_lo, 5'b0} + {2'b0, mag_lo, 3'b0} + {3'b0, mag_lo, 2'b0}
			+ {5'b0, mag_lo};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			div_s2.rem         <= num;
			div_s2.dsh         <= {mag_hi, 5'b0};
			div_s2.quot        <= '0;
			div_s2.side.xneg   <= xneg_s1;
			div_s2.side.yneg   <= yneg_s1;
			div_s2.side.mirror <= mirror;
			div_s2.side.zero   <= (ax_s1 == '0) && (ay_s1 == '0);
		end
	end

	assign out_valid = v_s2;
	assign out_data  = div_s2;

endmodule

// ===== design/fvad_div.sv =====
`timescale 1ns / 1ps
module fvad_div (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic                in_valid,
	input  fvad_pkg::fvad_div_t in_data,
	output logic                out_valid,
	output fvad_pkg::fvad_div_t out_data
);
	import fvad_pkg::*;

	fvad_div_t div_s3, div_s4, div_s5;
	logic      v_s3, v_s4, v_s5;
	fvad_div_t nxt3, nxt4, nxt5;

	// two restoring quotient bits against a divisor that halves each bit
	function automatic fvad_div_t div_step(input fvad_div_t d);
		fvad_div_t        r;
		logic             t0, t1;
		logic [NUM_W-1:0] r0, d1;
		t0     = d.rem >= d.dsh;
		r0     = t0 ? (d.rem - d.dsh) : d.rem;
		d1     = d.dsh >> 1;
		t1     = r0 >= d1;
		r      = d;
		r.rem  = t1 ? (r0 - d1) : r0;
		r.dsh  = d.dsh >> 2;
		r.quot = {d.quot[QUOT_W-3:0], t0, t1};
		return r;
	endfunction

	always_comb begin
		nxt3 = div_step(in_data);
		nxt4 = div_step(div_s3);
		nxt5 = div_step(div_s4);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s3 <= in_valid;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			div_s3 <= nxt3;
			div_s4 <= nxt4;
			div_s5 <= nxt5;
		end
	end

	assign out_valid = v_s5;
	assign out_data  = div_s5;

endmodule

// ===== design/fvad_back.sv =====
`timescale 1ns / 1ps
module fvad_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic                in_valid,
	input  fvad_pkg::fvad_div_t in_data,
	output logic                out_valid,
	output fvad_pkg::fvad_out_t out_data
);
	import fvad_pkg::*;

	logic [QUOT_W-1:0]  c;
	logic [2:0]         k;
	logic [6:0]         a;
	logic [ANGLE_W-1:0] ang;
	fvad_out_t          res_s6;
	logic               v_s6;

	// add stepwise correction, mirror, then place in quadrant; a zero vector gives angle 0
	always_comb begin
		c = in_data.quot;
		if (c > QUOT_W'(22)) begin
			k = 3'((c <= QUOT_W'(44))) + 3'((c <= QUOT_W'(41)))
				+ 3'((c <= QUOT_W'(37))) + 3'((c <= QUOT_W'(32)));
		end else begin
			k = 3'((c >= QUOT_W'(2))) + 3'((c >= QUOT_W'(6)))
				+ 3'((c >= QUOT_W'(10))) + 3'((c >= QUOT_W'(15)));
		end
		a = 7'(c) + 7'(k);
		if (in_data.side.mirror) begin
			a = 7'd90 - a;
		end
		if (in_data.side.yneg) begin
			ang = in_data.side.xneg ? (ANGLE_W'(180) + ANGLE_W'(a))
				: (ANGLE_W'(180) - ANGLE_W'(a));
		end else if (in_data.side.xneg) begin
			ang = ANGLE_W'(360) - ANGLE_W'(a);
		end else begin
			ang = ANGLE_W'(a);
		end
		if (in_data.side.zero) begin
			ang = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s6 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s6.angle_degrees <= ang;
			res_s6.zero_vector   <= in_data.side.zero;
		end
	end

	assign out_valid = v_s6;
	assign out_data  = res_s6;

endmodule

// ===== design/fast_vector_angle_degrees.sv =====
`timescale 1ns / 1ps
// Stages from request to result: magnitudes, scale, three
// two-bit divider stages, correction and quadrant mapping.
// Throughput: one vector per cycle; a stalled result holds the whole
// pipeline in place, nothing is dropped or repeated.
// Reset (arst_n low) clears all stage valid bits; data registers are not reset.
module fast_vector_angle_degrees (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  fvad_pkg::fvad_in_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output fvad_pkg::fvad_out_t out_data
);
	import fvad_pkg::*;

	logic      adv;
	logic      front_valid, div_valid;
	fvad_div_t front_data, div_data;

	// advance every stage unless the result waits on the consumer
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	fvad_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (in_valid),
		.in_data   (in_data),
		.out_valid (front_valid),
		.out_data  (front_data)
	);

	fvad_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (front_valid),
		.in_data   (front_data),
		.out_valid (div_valid),
		.out_data  (div_data)
	);

	fvad_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (div_valid),
		.in_data   (div_data),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
	import fvad_pkg::*;

	localparam int RAND_ITEMS  = 2000;
	localparam int DRAIN_CYC   = 20;
	localparam int STALL_LIMIT = 2000;

	typedef struct {
		fvad_in_t  vec;
		bit        typed;
		fvad_out_t res;
	} vec_row_t;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	fvad_in_t  in_data;
	logic      out_valid;
	logic      out_ready;
	fvad_out_t out_data;

	vec_row_t  vec_rows[$];
	fvad_out_t pending_angles[$];
	int        mismatch_cnt = 0;
	int        quiet_cycles = 0;
	int        steady_left  = 0;

	fast_vector_angle_degrees u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// compute the expected angle and zero flag for one vector
	function automatic fvad_out_t calc_angle(fvad_in_t v);
		fvad_out_t r;
		int xs, ys, ax, ay, raw, ang;
		bit mirror;
		xs = v.x_component;
		ys = v.y_component;
		ax = (xs < 0) ? -xs : xs;
		ay = (ys < 0) ? -ys : ys;
		r = '0;
		if (ax == 0 && ay == 0) begin
			r.zero_vector = 1'b1;
			return r;
		end
		if (ax > ay) begin
			raw = (ay * 45) / ax;
			mirror = 1'b1;
		end else begin
			raw = (ax * 45) / ay;
			mirror = 1'b0;
		end
		// stepwise correction, shaped differently above and below 22
		ang = raw;
		if (raw > 22) begin
			ang += (raw <= 44) + (raw <= 41) + (raw <= 37) + (raw <= 32);
		end else begin
			ang += (raw >= 2) + (raw >= 6) + (raw >= 10) + (raw >= 15);
		end
		if (mirror)
			ang = 90 - ang;
		// place the angle in the quadrant given by the signs
		if (ys < 0) begin
			ang = (xs < 0) ? 180 + ang : 180 - ang;
		end else if (xs < 0) begin
			ang = 360 - ang;
		end
		r.angle_degrees = ang[ANGLE_W-1:0];
		return r;
	endfunction

	// idle length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic add_row(int x, int y, bit typed, int ang, bit zero);
		vec_row_t row;
		row.vec.x_component = XY_W'(x);
		row.vec.y_component = XY_W'(y);
		row.typed = typed;
		row.res.angle_degrees = ANGLE_W'(ang);
		row.res.zero_vector = zero;
		vec_rows.push_back(row);
	endtask

	task automatic flag_mismatch(string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		mismatch_cnt++;
	endtask

	// offer one request, wait for acceptance, then log its expected result
	task automatic send_vector(fvad_in_t v, bit typed, fvad_out_t res);
		int gap;
		if (steady_left > 0) begin
			gap = 0;
			steady_left--;
		end else begin
			gap = pick_gap();
		end
		if (gap > 0) begin
			@(negedge clk) in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data  <= v;
		do @(posedge clk); while (!in_ready);
		pending_angles.push_back(typed ? res : calc_angle(v));
	endtask

	// drive requests: directed table first, then random vectors
	initial begin
		fvad_in_t  v;
		fvad_out_t none;
		int sel, base;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		none      = '0;

		// zero vector, axes, diagonals, extremes
		add_row(0, 0, 1, 0, 1);
		add_row(0, 1, 1, 0, 0);
		add_row(1, 0, 1, 90, 0);
		add_row(0, -1, 1, 180, 0);
		add_row(-1, 0, 1, 270, 0);
		add_row(1, 1, 1, 45, 0);
		add_row(1, -1, 1, 135, 0);
		add_row(-1, -1, 1, 225, 0);
		add_row(-1, 1, 1, 315, 0);
		add_row(2047, 0, 1, 90, 0);
		add_row(-2048, 0, 1, 270, 0);
		add_row(0, 2047, 1, 0, 0);
		add_row(0, -2048, 1, 180, 0);
		add_row(-2048, -2048, 1, 225, 0);
		add_row(2047, 2047, 1, 45, 0);
		add_row(1456, 1456, 1, 45, 0);
		add_row(-1456, 1456, 1, 315, 0);
		// correction bands and mirroring, checked by the predictor
		add_row(2047, -2048, 0, 0, 0);
		add_row(-2048, 2047, 0, 0, 0);
		add_row(1456, -1, 0, 0, 0);
		add_row(3, 100, 0, 0, 0);
		add_row(40, 100, 0, 0, 0);
		add_row(100, 60, 0, 0, 0);
		add_row(-7, -50, 0, 0, 0);
		add_row(1, -1456, 0, 0, 0);

		repeat (2) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		foreach (vec_rows[i])
			send_vector(vec_rows[i].vec, vec_rows[i].typed, vec_rows[i].res);

		for (int n = 0; n < RAND_ITEMS; n++) begin
			// now and then run a burst with no gaps
			if (steady_left == 0 && $urandom_range(0, 99) < 3)
				steady_left = $urandom_range(30, 80);
			sel = $urandom_range(0, 99);
			if (sel < 60) begin
				v.x_component = XY_W'($urandom_range(0, 2912) - 1456);
				v.y_component = XY_W'($urandom_range(0, 2912) - 1456);
			end else if (sel < 75) begin
				v.x_component = XY_W'($urandom());
				v.y_component = XY_W'($urandom());
			end else if (sel < 85) begin
				v.x_component = XY_W'($urandom_range(0, 16) - 8);
				v.y_component = XY_W'($urandom_range(0, 16) - 8);
			end else if (sel < 95) begin
				// near a diagonal
				base = $urandom_range(0, 2912) - 1456;
				v.x_component = XY_W'(base);
				v.y_component = XY_W'(($urandom_range(0, 1) ? base : -base)
					+ $urandom_range(0, 6) - 3);
			end else begin
				// on an axis, any length
				base = $urandom();
				v.x_component = $urandom_range(0, 1) ? 12'(base) : '0;
				v.y_component = (v.x_component == 0) ? 12'(base >> 12) : '0;
			end
			send_vector(v, 1'b0, none);
		end

		@(negedge clk) in_valid <= 1'b0;
		while (pending_angles.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// toggle result backpressure: ready stretches, short and long stalls
	initial begin
		int hold, stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			hold = ($urandom_range(0, 99) < 10) ? $urandom_range(50, 200)
				: $urandom_range(1, 8);
			@(negedge clk) out_ready <= 1'b1;
			repeat (hold - 1) @(negedge clk);
			stall = pick_gap();
			if (stall > 0) begin
				@(negedge clk) out_ready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
		end
	end

	// compare each accepted result with the oldest expected one
	always @(posedge clk) begin
		fvad_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_angles.size() == 0) begin
				flag_mismatch($sformatf("unexpected result angle=%0d zero=%0b",
					out_data.angle_degrees, out_data.zero_vector));
			end else begin
				want = pending_angles.pop_front();
				if (out_data.angle_degrees !== want.angle_degrees)
					flag_mismatch($sformatf("angle_degrees got %0d want %0d",
						out_data.angle_degrees, want.angle_degrees));
				if (out_data.zero_vector !== want.zero_vector)
					flag_mismatch($sformatf("zero_vector got %0b want %0b",
						out_data.zero_vector, want.zero_vector));
			end
		end
	end

	// stop a hung run: count cycles with no request or result moving
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("ERROR @%0t: no handshake for %0d cycles", $realtime, quiet_cycles);
			$display("Simulation FAILED");
			$finish;
		end
	end

endmodule
